// File: design/i2cbw_pkg.sv
// Shared types and constants for the two-byte I2C command writer.
package i2cbw_pkg;

  // Stream widths
  localparam int IN_DATA_W  = 24;  // command_word, sda_in, scl_in, padded to bytes
  localparam int OUT_DATA_W = 8;   // six result fields, padded to a byte

  localparam int QUEUE_DEPTH = 2;

  // Input kind as carried on in_tuser
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // Classified item codes
  localparam logic [1:0] ITEM_TICK    = 2'd0;
  localparam logic [1:0] ITEM_LOAD    = 2'd1;
  localparam logic [1:0] ITEM_INVALID = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_BUSY    = 2'd2;

  // Command decode
  localparam logic [7:0] SYS_PREFIX   = 8'h04;
  localparam logic [3:0] DIGIT_PREFIX = 4'h1;
  localparam logic [7:0] SYS_ADDR     = 8'h48;
  localparam logic [7:0] DIGIT_BASE   = 8'h60;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       sda_in;
    logic       scl_in;
  } item_t;

endpackage

// File: design/i2cbw_front.sv
// Front end: accepts input beats and decodes command words into queue items.
module i2cbw_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [i2cbw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             push_valid,
  input  logic                             push_ready,
  output i2cbw_pkg::item_t                 push_item
);
  import i2cbw_pkg::*;

  logic [15:0] word;

  assign word       = in_tdata[15:0];
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_item.sda_in      = in_tdata[16];
    push_item.scl_in      = in_tdata[17];
    push_item.second_byte = word[7:0];
    push_item.first_byte  = SYS_ADDR;
    if (in_tuser == KIND_TICK) begin
      push_item.code = ITEM_TICK;
    end else if (word[15:8] == SYS_PREFIX) begin
      push_item.code = ITEM_LOAD;
    end else if (word[15:12] == DIGIT_PREFIX) begin
      // digit address: base plus twice the digit number
      push_item.code       = ITEM_LOAD;
      push_item.first_byte = DIGIT_BASE + {3'b000, word[11:8], 1'b0};
    end else begin
      push_item.code = ITEM_INVALID;
    end
  end

endmodule

// File: design/i2cbw_queue.sv
// Small register queue between the decoder and the bus engine.
module i2cbw_queue #(
  parameter int DEPTH = i2cbw_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  i2cbw_pkg::item_t  push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output i2cbw_pkg::item_t  pop_item
);
  import i2cbw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/i2cbw_engine.sv
// Bus engine: steps the open-drain I2C frame one item per beat and registers the result.
module i2cbw_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  i2cbw_pkg::item_t                  item,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbw_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import i2cbw_pkg::*;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_S_SDA_HI  = 5'd1;
  localparam logic [4:0] PH_S_SCL_HI  = 5'd2;
  localparam logic [4:0] PH_S_SDA_LO  = 5'd3;
  localparam logic [4:0] PH_S_SCL_LO  = 5'd4;
  localparam logic [4:0] PH_B_SDA     = 5'd5;
  localparam logic [4:0] PH_B_SCL_HI  = 5'd6;
  localparam logic [4:0] PH_B_SCL_LO  = 5'd7;
  localparam logic [4:0] PH_A_SDA_REL = 5'd8;
  localparam logic [4:0] PH_A_SCL_HI  = 5'd9;
  localparam logic [4:0] PH_A_SAMPLE  = 5'd10;
  localparam logic [4:0] PH_P_SDA_LO  = 5'd11;
  localparam logic [4:0] PH_P_SCL_HI  = 5'd12;
  localparam logic [4:0] PH_P_SDA_HI  = 5'd13;

  logic [4:0] phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic       byte_sel_r, byte_sel_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       ack_r, ack_nxt;
  logic       sda_drv_r, sda_drv_nxt;
  logic       scl_drv_r, scl_drv_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic       take;
  logic       busy_now, busy_after;
  logic       done, acked;
  logic [1:0] status;
  logic [7:0] cur_byte;

  assign item_ready = !out_valid_r || out_tready;
  assign take       = item_valid && item_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign busy_now   = phase_r inside {[PH_S_SDA_HI:PH_P_SDA_HI]};
  assign busy_after = phase_nxt inside {[PH_S_SDA_HI:PH_P_SDA_HI]};
  assign cur_byte   = byte_sel_r ? second_r : first_r;

  always_comb begin
    phase_nxt    = phase_r;
    bit_idx_nxt  = bit_idx_r;
    byte_sel_nxt = byte_sel_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    ack_nxt      = ack_r;
    sda_drv_nxt  = sda_drv_r;
    scl_drv_nxt  = scl_drv_r;
    done         = 1'b0;
    acked        = 1'b0;
    status       = STATUS_OK;

    if (item.code != ITEM_TICK) begin
      // busy is checked before the word's class
      if (busy_now) begin
        status = STATUS_BUSY;
      end else if (item.code == ITEM_INVALID) begin
        status    = STATUS_INVALID;
        phase_nxt = PH_IDLE;
      end else begin
        first_nxt    = item.first_byte;
        second_nxt   = item.second_byte;
        ack_nxt      = 1'b1;
        bit_idx_nxt  = 4'd0;
        byte_sel_nxt = 1'b0;
        phase_nxt    = PH_S_SDA_HI;
      end
    end else begin
      case (phase_r)
        PH_S_SDA_HI: begin
          sda_drv_nxt = 1'b0;
          phase_nxt   = PH_S_SCL_HI;
        end
        PH_S_SCL_HI, PH_B_SCL_HI, PH_A_SCL_HI, PH_P_SCL_HI: begin
          // release SCL and hold while a slave stretches it low
          scl_drv_nxt = 1'b0;
          if (item.scl_in) begin
            phase_nxt = phase_r + 5'd1;
          end
        end
        PH_S_SDA_LO: begin
          sda_drv_nxt = 1'b1;
          phase_nxt   = PH_S_SCL_LO;
        end
        PH_S_SCL_LO: begin
          scl_drv_nxt  = 1'b1;
          bit_idx_nxt  = 4'd7;
          byte_sel_nxt = 1'b0;
          phase_nxt    = PH_B_SDA;
        end
        PH_B_SDA: begin
          sda_drv_nxt = !cur_byte[bit_idx_r[2:0]];
          phase_nxt   = PH_B_SCL_HI;
        end
        PH_B_SCL_LO: begin
          scl_drv_nxt = 1'b1;
          if (bit_idx_r == 4'd0) begin
            phase_nxt = PH_A_SDA_REL;
          end else begin
            bit_idx_nxt = bit_idx_r - 4'd1;
            phase_nxt   = PH_B_SDA;
          end
        end
        PH_A_SDA_REL: begin
          sda_drv_nxt = 1'b0;
          phase_nxt   = PH_A_SCL_HI;
        end
        PH_A_SAMPLE: begin
          if (item.sda_in) begin
            ack_nxt = 1'b0;
          end
          scl_drv_nxt = 1'b1;
          if (!byte_sel_r) begin
            byte_sel_nxt = 1'b1;
            bit_idx_nxt  = 4'd7;
            phase_nxt    = PH_B_SDA;
          end else begin
            phase_nxt = PH_P_SDA_LO;
          end
        end
        PH_P_SDA_LO: begin
          sda_drv_nxt = 1'b1;
          phase_nxt   = PH_P_SCL_HI;
        end
        PH_P_SDA_HI: begin
          sda_drv_nxt = 1'b0;
          done        = 1'b1;
          acked       = ack_r;
          phase_nxt   = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    out_data_nxt = {1'b0, status, acked, done, busy_after, scl_drv_nxt, sda_drv_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_idx_r   <= 4'd0;
      byte_sel_r  <= 1'b0;
      first_r     <= 8'd0;
      second_r    <= 8'd0;
      ack_r       <= 1'b1;
      sda_drv_r   <= 1'b0;
      scl_drv_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r    <= phase_nxt;
        bit_idx_r  <= bit_idx_nxt;
        byte_sel_r <= byte_sel_nxt;
        first_r    <= first_nxt;
        second_r   <= second_nxt;
        ack_r      <= ack_nxt;
        sda_drv_r  <= sda_drv_nxt;
        scl_drv_r  <= scl_drv_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: design/i2c_two_byte_command_writer.sv
// Top level of the two-byte I2C command writer.
// Every input beat (a delay tick or a command word) yields exactly one result beat with the
// SDA/SCL pull-low levels, busy, frame-done, frame-acked and a status code. Commands 0x04xx
// send the frame 0x48, xx; commands 0x1Dxx send 0x60+2*D, xx; any other word, or any command
// during a frame, is rejected. The block takes one beat per clock while the queue has room: the decoder pushes into a
// two-entry queue and the bus engine applies one queued item per clock, unless its output is held, into its output
// register, so a result passes through a queue slot and then the output register.
// The queue lets input keep flowing while the result side is held, until the queue is full.
module i2c_two_byte_command_writer #(
  parameter int QDEPTH = i2cbw_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cbw_pkg::IN_DATA_W-1:0]   in_tdata,  // [15:0] command_word, [16] sda_in,
                                                       // [17] scl_in, [23:18] zero
  input  logic                              in_tuser,  // [0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbw_pkg::OUT_DATA_W-1:0]  out_tdata  // [0] sda_pull_low, [1] scl_pull_low,
                                                       // [2] busy_res, [3] frame_done,
                                                       // [4] frame_acked, [6:5] status, [7] 0
);
  import i2cbw_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  i2cbw_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2cbw_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  i2cbw_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A popped item always lands in the output register
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> out_tvalid)
    else $error("queued item taken without a result");

  // A finished frame leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("frame done while still busy");

  // Ack is only reported with frame completion
  a_ack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3])
    else $error("frame ack without frame done");

  // A rejected command never completes a frame
  a_reject_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[6:5] == STATUS_INVALID || out_tdata[6:5] == STATUS_BUSY)
      |-> !out_tdata[3])
    else $error("rejected command reported frame done");

endmodule
